// File: src/utf8_stream_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define USD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/usd_pkg.sv
// Types, constants and helper functions for the UTF-8 stream decoder.
package usd_pkg;

    localparam int MAX_SEQUENCE_BYTES = 6;

    localparam logic [2:0] ST_CHAR     = 3'd0;
    localparam logic [2:0] ST_BAD_HEAD = 3'd1;
    localparam logic [2:0] ST_BAD_TAIL = 3'd2;
    localparam logic [2:0] ST_OVERLONG = 3'd3;
    localparam logic [2:0] ST_END      = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_mark;
    } usd_in_t;

    typedef struct packed {
        logic [30:0] code_point;
        logic [2:0]  status;
    } usd_out_t;

    typedef struct packed {
        logic     has_result;
        usd_out_t result;
    } usd_step_t;

    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        casez (b)
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] shortest_len(input logic [30:0] v);
        logic [2:0] n;
        if (v < 31'h80)            n = 3'd1;
        else if (v < 31'h800)      n = 3'd2;
        else if (v < 31'h10000)    n = 3'd3;
        else if (v < 31'h200000)   n = 3'd4;
        else if (v < 31'h4000000)  n = 3'd5;
        else                       n = 3'd6;
        return n;
    endfunction

endpackage

// File: src/usd_in_reg.sv
// Input register: holds one byte transaction until the decoder consumes it.
module usd_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  usd_pkg::usd_in_t byte_item,
    input  logic             advance,
    output logic             hold_valid,
    output usd_pkg::usd_in_t hold_item
);
    import usd_pkg::*;

    logic    hold_valid_reg;
    logic    hold_valid_next;
    usd_in_t hold_item_reg;

    assign byte_stall      = hold_valid_reg && !advance;
    assign hold_valid_next = byte_stall ? hold_valid_reg : byte_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            hold_item_reg <= byte_item;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_item  = hold_item_reg;

endmodule

// File: src/usd_decode.sv
// Sequence state and single-pass decode of one byte into an optional result.
module usd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  usd_pkg::usd_in_t   item,
    output usd_pkg::usd_step_t step
);
    import usd_pkg::*;

    logic [30:0] partial_reg, partial_next;
    logic [2:0]  tails_reg, tails_next;
    logic [2:0]  seq_len_reg, seq_len_next;

    logic [3:0]  lead;
    logic [30:0] shifted;

    assign lead    = lead_ones(item.data_byte);
    assign shifted = {partial_reg[24:0], item.data_byte[5:0]};

    always_comb
    begin
        partial_next = partial_reg;
        tails_next   = tails_reg;
        seq_len_next = seq_len_reg;
        step         = '0;
        if (tails_reg == 3'd0)
        begin
            priority if (item.end_mark)
            begin
                step.has_result    = 1'b1;
                step.result.status = ST_END;
            end
            else if (lead == 4'd0)
            begin
                step.has_result        = 1'b1;
                step.result.code_point = {23'd0, item.data_byte};
                step.result.status     = ST_CHAR;
            end
            else if (lead < 4'd2 || lead > 4'(MAX_SEQUENCE_BYTES))
            begin
                step.has_result    = 1'b1;
                step.result.status = ST_BAD_HEAD;
            end
            else
            begin
                partial_next = {23'd0, item.data_byte & (8'hFF >> lead)};
                seq_len_next = lead[2:0];
                tails_next   = lead[2:0] - 3'd1;
            end
        end
        else
        begin
            priority if (item.end_mark)
            begin
                partial_next       = '0;
                tails_next         = 3'd0;
                seq_len_next       = 3'd0;
                step.has_result    = 1'b1;
                step.result.status = ST_TRUNC;
            end
            else if (item.data_byte[7:6] != 2'b10)
            begin
                partial_next       = '0;
                tails_next         = 3'd0;
                seq_len_next       = 3'd0;
                step.has_result    = 1'b1;
                step.result.status = ST_BAD_TAIL;
            end
            else if (tails_reg != 3'd1)
            begin
                partial_next = shifted;
                tails_next   = tails_reg - 3'd1;
            end
            else
            begin
                partial_next    = '0;
                tails_next      = 3'd0;
                seq_len_next    = 3'd0;
                step.has_result = 1'b1;
                if (shortest_len(shifted) != seq_len_reg)
                begin
                    step.result.status = ST_OVERLONG;
                end
                else
                begin
                    step.result.code_point = shifted;
                    step.result.status     = ST_CHAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            tails_reg   <= 3'd0;
            seq_len_reg <= 3'd0;
        end
        else if (fire)
        begin
            partial_reg <= partial_next;
            tails_reg   <= tails_next;
            seq_len_reg <= seq_len_next;
        end
    end

endmodule

// File: src/usd_out_reg.sv
// Result register: holds one result transaction while the receiver stalls.
module usd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  usd_pkg::usd_step_t step,
    output logic               out_ready,
    output logic               char_valid,
    input  logic               char_stall,
    output usd_pkg::usd_out_t  char_item
);
    import usd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    usd_out_t item_reg;

    assign out_ready  = !valid_reg || !char_stall;
    assign valid_next = out_ready ? (fire && step.has_result) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && fire && step.has_result)
        begin
            item_reg <= step.result;
        end
    end

    assign char_valid = valid_reg;
    assign char_item  = item_reg;

endmodule

// File: src/utf8_stream_decoder.sv
// Top level of the UTF-8 (six-byte form) stream decoder.
// Usage:
//   Byte channel (byte_valid/byte_stall/byte_item): one transaction per raw
//   byte, or an end mark with end_mark set. Accepted when valid and not stall.
//   Result channel (char_valid/char_stall/char_item): code point and status.
//   A one-byte character, a completed sequence, every error and the end mark
//   each give one result; head and middle bytes of a sequence give none.
// Data path: a byte is taken into the input register, decoded in one pass and
//   its result is loaded into the result register once that register is free.
// Throughput: one byte per cycle while char_stall does not hold a waiting
//   result; the decode between the input register and the result register is
//   combinational, and the sequence state updates once per byte.
// Stall: while char_stall holds a waiting result, one more byte is still
//   taken into the input register; byte_stall rises only when the input
//   register and the result register are both full and char_stall is high.
// Reset: rst_n clears all valid flags and returns the decoder to idle with
//   no partial sequence.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  usd_pkg::usd_in_t  byte_item,
    output logic              char_valid,
    input  logic              char_stall,
    output usd_pkg::usd_out_t char_item
);
    import usd_pkg::*;

    logic      hold_valid;
    usd_in_t   hold_item;
    logic      out_ready;
    logic      fire;
    usd_step_t step;

    assign fire = hold_valid && out_ready;

    usd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .advance    (out_ready),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    usd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (hold_item),
        .step  (step)
    );

    usd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .step       (step),
        .out_ready  (out_ready),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    `USD_ASSERT_NOW(a_zero_on_error, char_valid && char_item.status != ST_CHAR,
        char_item.code_point == 31'd0, "code point not zero on error status")
    `USD_ASSERT_NOW(a_status_range, char_valid,
        char_item.status <= ST_TRUNC, "status code out of range")
    `USD_ASSERT_NOW(a_stall_needs_full, byte_stall,
        hold_valid && char_valid, "byte stall without both registers full")
    `USD_ASSERT_NEXT(a_result_source, !char_valid && !fire,
        !char_valid, "result appeared without a decoded transaction")

endmodule
